>>> hdl/collapsing_request_queue_macros.svh
`ifndef COLLAPSING_REQUEST_QUEUE_MACROS_SVH
`define COLLAPSING_REQUEST_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/crq_pkg.sv
package crq_pkg;

  localparam int OP_W           = 2;
  localparam int IDX_FIELD_W    = 3;
  localparam int PAYLOAD_FIELD_W = 64;
  localparam int OCC_FIELD_W    = 4;
  localparam int IN_TDATA_W     = 72;
  localparam int OUT_TDATA_W    = 80;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_COMPACT = 2'd2,
    OP_READ    = 2'd3
  } crq_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDATA,
    S_COMPACT,
    S_FINISH
  } crq_state_t;

endpackage

>>> hdl/crq_slot_mem.sv
module crq_slot_mem #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/collapsing_request_queue.sv
// Collapsing request queue: slot payloads in a one-port-write, one-port-read RAM,
// valid bits and occupancy in flops.
// Push/release answer on accept; read passes S_RDATA, compact walks S_COMPACT then S_FINISH.
// Throughput: one word in flight; the compact walk visits one slot per cycle.
// In S_IDLE a new word is taken once the output register is empty or drains in that cycle.
// Reset (rst_n low, synchronous) clears all valid bits and occupancy; no RAM sweep.
module collapsing_request_queue #(
  parameter int SLOT_COUNT    = 8,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // operation[1:0], slot_index[4:2], payload_in[68:5], zero pad
  input  logic [crq_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // accepted[0], chosen_slot[3:1], read_valid[4], read_payload[68:5],
  // occupancy[72:69], zero pad
  output logic [crq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import crq_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int OCC_W = $clog2(SLOT_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

  function automatic logic [OCC_FIELD_W-1:0] occ_field(input logic [OCC_W-1:0] v);
    logic [6:0] w;
    begin
      w = 7'(v);
      return w[OCC_FIELD_W-1:0];
    end
  endfunction

  crq_state_t state_r, state_nxt;
  logic [SLOT_COUNT-1:0]  valid_r, valid_nxt;
  logic [OCC_W-1:0]       occ_r, occ_nxt;
  logic [IDX_W-1:0]       src_r, src_nxt;
  logic [IDX_W-1:0]       dst_r, dst_nxt;
  logic                   mv_pend_r, mv_pend_nxt;
  logic [IDX_W-1:0]       mv_dst_r, mv_dst_nxt;
  logic                   rd_hit_r, rd_hit_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_acc_r, out_acc_nxt;
  logic [IDX_FIELD_W-1:0]     out_chosen_r, out_chosen_nxt;
  logic                       out_rvalid_r, out_rvalid_nxt;
  logic [PAYLOAD_FIELD_W-1:0] out_rdata_r, out_rdata_nxt;
  logic [OCC_FIELD_W-1:0]     out_occ_r, out_occ_nxt;

  logic [OP_W-1:0]          in_op;
  logic [IDX_FIELD_W-1:0]   in_idx_raw;
  logic [6:0]               in_idx_ext;
  logic                     in_range;
  logic [IDX_W-1:0]         in_idx;
  logic [PAYLOAD_WIDTH-1:0] in_payload;

  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [6:0]               free_idx_ext;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [PAYLOAD_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]         mem_raddr;
  logic [PAYLOAD_WIDTH-1:0] mem_rdata;

  assign in_op      = in_tdata[OP_W-1:0];
  assign in_idx_raw = in_tdata[OP_W +: IDX_FIELD_W];
  assign in_payload = in_tdata[OP_W + IDX_FIELD_W +: PAYLOAD_WIDTH];
  assign in_idx_ext = 7'(in_idx_raw);
  assign in_range   = in_idx_ext < 7'(SLOT_COUNT);
  assign in_idx     = in_idx_ext[IDX_W-1:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
  end

  assign free_idx_ext = 7'(free_idx);

  crq_slot_mem #(
    .DEPTH  (SLOT_COUNT),
    .DATA_W (PAYLOAD_WIDTH)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    occ_nxt        = occ_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    mv_pend_nxt    = 1'b0;
    mv_dst_nxt     = mv_dst_r;
    rd_hit_nxt     = rd_hit_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_acc_nxt    = out_acc_r;
    out_chosen_nxt = out_chosen_r;
    out_rvalid_nxt = out_rvalid_r;
    out_rdata_nxt  = out_rdata_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = mv_pend_r;
    mem_waddr      = mv_dst_r;
    mem_wdata      = mem_rdata;
    mem_raddr      = src_r;
    in_tready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = !out_valid_r || out_tready;
        mem_raddr = in_idx;
        if (in_tvalid && in_tready) begin
          case (crq_op_t'(in_op))
            OP_PUSH: begin
              out_valid_nxt  = 1'b1;
              out_acc_nxt    = free_found;
              out_chosen_nxt = free_found ? free_idx_ext[IDX_FIELD_W-1:0] : '0;
              out_rvalid_nxt = 1'b0;
              out_rdata_nxt  = '0;
              if (free_found) begin
                valid_nxt[free_idx] = 1'b1;
                occ_nxt   = occ_r + 1'b1;
                mem_we    = 1'b1;
                mem_waddr = free_idx;
                mem_wdata = in_payload;
              end
              out_occ_nxt = occ_field(occ_nxt);
            end
            OP_RELEASE: begin
              if (in_range) begin
                valid_nxt[in_idx] = 1'b0;
                if (valid_r[in_idx]) begin
                  occ_nxt = occ_r - 1'b1;
                end
              end
              out_valid_nxt  = 1'b1;
              out_acc_nxt    = 1'b0;
              out_chosen_nxt = '0;
              out_rvalid_nxt = 1'b0;
              out_rdata_nxt  = '0;
              out_occ_nxt    = occ_field(occ_nxt);
            end
            OP_COMPACT: begin
              src_nxt   = '0;
              dst_nxt   = '0;
              state_nxt = S_COMPACT;
            end
            OP_READ: begin
              rd_hit_nxt = in_range && valid_r[in_idx];
              state_nxt  = S_RDATA;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RDATA: begin
        out_valid_nxt  = 1'b1;
        out_acc_nxt    = 1'b0;
        out_chosen_nxt = '0;
        out_rvalid_nxt = rd_hit_r;
        out_rdata_nxt  = rd_hit_r ? PAYLOAD_FIELD_W'(mem_rdata) : '0;
        out_occ_nxt    = occ_field(occ_r);
        state_nxt      = S_IDLE;
      end
      S_COMPACT: begin
        if (valid_r[src_r]) begin
          if (src_r != dst_r) begin
            valid_nxt[dst_r] = 1'b1;
            valid_nxt[src_r] = 1'b0;
            mv_pend_nxt      = 1'b1;
            mv_dst_nxt       = dst_r;
          end
          dst_nxt = dst_r + 1'b1;
        end
        if (src_r == LAST_SLOT) begin
          state_nxt = S_FINISH;
        end else begin
          src_nxt = src_r + 1'b1;
        end
      end
      S_FINISH: begin
        out_valid_nxt  = 1'b1;
        out_acc_nxt    = 1'b0;
        out_chosen_nxt = '0;
        out_rvalid_nxt = 1'b0;
        out_rdata_nxt  = '0;
        out_occ_nxt    = occ_field(occ_r);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      occ_r       <= '0;
      mv_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      occ_r       <= occ_nxt;
      mv_pend_r   <= mv_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    mv_dst_r     <= mv_dst_nxt;
    rd_hit_r     <= rd_hit_nxt;
    out_acc_r    <= out_acc_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_rvalid_r <= out_rvalid_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_occ_r, out_rdata_r, out_rvalid_r, out_chosen_r, out_acc_r};

endmodule

>>> hdl/crq_checker.sv
`include "collapsing_request_queue_macros.svh"

module crq_checker #(
  parameter int SLOT_COUNT = 8
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [crq_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import crq_pkg::*;

  `CRQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `CRQ_ASSERT_NOW(a_no_take_when_blocked, in_tready, !out_tvalid || out_tready, "input taken while result word blocked")
  `CRQ_ASSERT_NOW(a_occ_bound, out_tvalid, (SLOT_COUNT > 15) || (out_tdata[72:69] <= 4'(SLOT_COUNT)), "occupancy above depth")
  `CRQ_ASSERT_NOW(a_refused_slot_zero, out_tvalid && !out_tdata[0], out_tdata[3:1] == 3'd0, "refused push reports a slot")
  `CRQ_ASSERT_NOW(a_push_read_excl, out_tvalid, !(out_tdata[0] && out_tdata[4]), "push and read flags both set")

endmodule

bind collapsing_request_queue crq_checker #(.SLOT_COUNT(SLOT_COUNT)) u_crq_checker (.*);

>>> bench/tb_top.sv
module tb_top;
  import crq_pkg::*;

  localparam int DEPTH = 8;
  localparam int PW = 64;
  localparam int N_DIRECTED = 25;
  localparam int N_PER_PHASE = 375;

  typedef struct packed {
    logic          accepted;
    logic [2:0]    chosen_slot;
    logic          read_valid;
    logic [PW-1:0] read_payload;
    logic [3:0]    occupancy;
  } queue_reply_t;

  typedef struct packed {
    crq_op_t       op;
    logic [2:0]    idx;
    logic [PW-1:0] payload;
    logic          typed;
    queue_reply_t  want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic          shadow_valid [DEPTH];
  logic [PW-1:0] shadow_payload [DEPTH];
  queue_reply_t  pending_replies [$];
  queue_reply_t  want_reply;
  int            mismatch_count = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;

  localparam queue_reply_t NONE = '0;

  // op, slot, payload, typed, {accepted, chosen, read_valid, read_payload, occupancy}
  stim_row_t directed [N_DIRECTED] = '{
    '{OP_READ,    3'd0, 64'd0,                  1'b1, '{1'b0, 3'd0, 1'b0, 64'd0, 4'd0}},
    '{OP_READ,    3'd7, 64'd0,                  1'b1, '{1'b0, 3'd0, 1'b0, 64'd0, 4'd0}},
    '{OP_COMPACT, 3'd0, 64'd0,                  1'b1, '{1'b0, 3'd0, 1'b0, 64'd0, 4'd0}},
    '{OP_RELEASE, 3'd3, 64'd0,                  1'b1, '{1'b0, 3'd0, 1'b0, 64'd0, 4'd0}},
    '{OP_PUSH,    3'd0, 64'hffff_ffff_ffff_ffff, 1'b1, '{1'b1, 3'd0, 1'b0, 64'd0, 4'd1}},
    '{OP_PUSH,    3'd7, 64'd0,                  1'b1, '{1'b1, 3'd1, 1'b0, 64'd0, 4'd2}},
    '{OP_PUSH,    3'd0, 64'h8000_0000_0000_0001, 1'b0, NONE},
    '{OP_PUSH,    3'd0, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0, NONE},
    '{OP_PUSH,    3'd0, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0, NONE},
    '{OP_PUSH,    3'd0, 64'h0123_4567_89ab_cdef, 1'b0, NONE},
    '{OP_PUSH,    3'd0, 64'hfedc_ba98_7654_3210, 1'b0, NONE},
    '{OP_PUSH,    3'd0, 64'h7fff_ffff_ffff_ffff, 1'b0, NONE},
    '{OP_PUSH,    3'd0, 64'h0000_0000_0000_dead, 1'b1, '{1'b0, 3'd0, 1'b0, 64'd0, 4'd8}},
    '{OP_READ,    3'd0, 64'd0,  1'b1, '{1'b0, 3'd0, 1'b1, 64'hffff_ffff_ffff_ffff, 4'd8}},
    '{OP_RELEASE, 3'd0, 64'd0,                  1'b0, NONE},
    '{OP_RELEASE, 3'd2, 64'd0,                  1'b0, NONE},
    '{OP_RELEASE, 3'd5, 64'd0,                  1'b0, NONE},
    '{OP_RELEASE, 3'd2, 64'd0,                  1'b0, NONE},
    '{OP_READ,    3'd2, 64'd0,                  1'b0, NONE},
    '{OP_COMPACT, 3'd0, 64'd0,                  1'b0, NONE},
    '{OP_READ,    3'd4, 64'd0,                  1'b0, NONE},
    '{OP_READ,    3'd7, 64'd0,                  1'b0, NONE},
    '{OP_PUSH,    3'd0, 64'hffff_ffff_ffff_ffff, 1'b0, NONE},
    '{OP_RELEASE, 3'd7, 64'd0,                  1'b0, NONE},
    '{OP_COMPACT, 3'd0, 64'd0,                  1'b0, NONE}
  };

  collapsing_request_queue #(
    .SLOT_COUNT   (DEPTH),
    .PAYLOAD_WIDTH(PW)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic queue_reply_t predict_reply(crq_op_t op, logic [2:0] idx,
                                                 logic [PW-1:0] data);
    queue_reply_t r;
    bit           done;
    int           cnt;
    r = '0;
    done = 1'b0;
    cnt = 0;
    case (op)
      OP_PUSH: begin
        for (int k = 0; k < DEPTH; k++) begin
          if (!done && !shadow_valid[k]) begin
            shadow_valid[k] = 1'b1;
            shadow_payload[k] = data;
            r.accepted = 1'b1;
            r.chosen_slot = k[2:0];
            done = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        shadow_valid[idx] = 1'b0;
        shadow_payload[idx] = '0;
      end
      OP_COMPACT: begin
        for (int src = 1; src < DEPTH; src++) begin
          done = 1'b0;
          if (shadow_valid[src]) begin
            for (int dst = 0; dst < src; dst++) begin
              if (!done && !shadow_valid[dst]) begin
                shadow_payload[dst] = shadow_payload[src];
                shadow_valid[dst] = 1'b1;
                shadow_payload[src] = '0;
                shadow_valid[src] = 1'b0;
                done = 1'b1;
              end
            end
          end
        end
      end
      OP_READ: begin
        r.read_valid = shadow_valid[idx];
        r.read_payload = shadow_payload[idx];
      end
      default: ;
    endcase
    for (int k = 0; k < DEPTH; k++) cnt += shadow_valid[k];
    r.occupancy = cnt[3:0];
    return r;
  endfunction

  task automatic issue_request(crq_op_t op, logic [2:0] idx, logic [PW-1:0] data,
                               logic typed, queue_reply_t want);
    queue_reply_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'd0, data, idx, op};
    do @(posedge clk); while (!in_tready);
    pred = predict_reply(op, idx, data);
    pending_replies.push_back(typed ? want : pred);
  endtask

  function automatic void check_field(string name, logic [PW-1:0] exp_v, logic [PW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        want_reply = pending_replies.pop_front();
        check_field("accepted", want_reply.accepted, out_tdata[0]);
        check_field("chosen_slot", want_reply.chosen_slot, out_tdata[3:1]);
        check_field("read_valid", want_reply.read_valid, out_tdata[4]);
        check_field("read_payload", want_reply.read_payload, out_tdata[68:5]);
        check_field("occupancy", want_reply.occupancy, out_tdata[72:69]);
      end
    end
  end

  initial begin
    int            sender_idle [4];
    int            recv_stall [4];
    int            pick;
    int            push_w;
    int            rel_w;
    crq_op_t       op;
    logic [PW-1:0] data;
    sender_idle = '{0, 63, 0, 9};
    recv_stall = '{0, 0, 63, 9};
    for (int k = 0; k < DEPTH; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_payload[k] = '0;
    end
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      issue_request(directed[i].op, directed[i].idx, directed[i].payload,
                    directed[i].typed, directed[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      // drain fully before each phase
      in_tvalid <= 1'b0;
      do @(posedge clk); while (pending_replies.size() != 0);
      idle_pct = sender_idle[ph];
      stall_pct = recv_stall[ph];
      for (int i = 0; i < N_PER_PHASE; i++) begin
        // alternate fill-heavy and drain-heavy stretches
        push_w = ((i / 60) % 2 == 0) ? 60 : 20;
        rel_w = ((i / 60) % 2 == 0) ? 15 : 45;
        pick = $urandom_range(99);
        if (pick < push_w) op = OP_PUSH;
        else if (pick < push_w + rel_w) op = OP_RELEASE;
        else if (pick < push_w + rel_w + 10) op = OP_COMPACT;
        else op = OP_READ;
        case ($urandom_range(7))
          0: data = '0;
          1: data = '1;
          default: data = {$urandom, $urandom};
        endcase
        issue_request(op, 3'($urandom_range(7)), data, 1'b0, NONE);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> collapsing_request_queue.f
+incdir+hdl
hdl/crq_pkg.sv
hdl/crq_slot_mem.sv
hdl/collapsing_request_queue.sv
hdl/crq_checker.sv
bench/tb_top.sv
